// ===== hdl/tmcw_pkg.sv =====
// Shared constants and types for the text mode console writer.
// Used by tmcw_cursor, text_mode_console_writer and tb; no dependencies.
package tmcw_pkg;

	localparam int DEF_COLUMNS   = 80;
	localparam int DEF_ROWS      = 25;
	localparam int DEF_TAB_CELLS = 4;

	localparam int CELL_W   = 16;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 11;
	localparam logic [CHAR_W-1:0] ATTR_RESET = 8'd7;

	// input commands
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// control bytes
	localparam logic [CHAR_W-1:0] BYTE_NUL = 8'd0;
	localparam logic [CHAR_W-1:0] BYTE_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] BYTE_NL  = 8'd10;
	localparam logic [CHAR_W-1:0] BYTE_VT  = 8'd11;
	localparam logic [CHAR_W-1:0] BYTE_FF  = 8'd12;
	localparam logic [CHAR_W-1:0] BYTE_CR  = 8'd13;

	// cursor operations
	localparam logic [2:0] CUR_NONE  = 3'd0;
	localparam logic [2:0] CUR_PRINT = 3'd1;
	localparam logic [2:0] CUR_NL    = 3'd2;
	localparam logic [2:0] CUR_CR    = 3'd3;
	localparam logic [2:0] CUR_TAB   = 3'd4;
	localparam logic [2:0] CUR_VT    = 3'd5;
	localparam logic [2:0] CUR_HOME  = 3'd6;

	typedef struct packed {
		logic       go;
		logic [2:0] op;
	} cur_ctrl_t;

endpackage

// ===== hdl/tmcw_screen_ram.sv =====
// Screen cell store: one write port, one registered read port.
// No dependencies.
module tmcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/tmcw_cursor.sv =====
// Cursor, column and scroll base registers with their update logic.
// Depends on tmcw_pkg.
module tmcw_cursor #(
	parameter int COLUMNS   = tmcw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tmcw_pkg::DEF_ROWS,
	parameter int TAB_CELLS = tmcw_pkg::DEF_TAB_CELLS,
	localparam int CELLS    = COLUMNS * ROWS,
	localparam int AW       = $clog2(CELLS),
	localparam int CUR_W    = $clog2(CELLS + COLUMNS + TAB_CELLS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tmcw_pkg::cur_ctrl_t ctrl,
	output logic [CUR_W-1:0]    cursor,
	output logic [AW-1:0]       base,
	output logic                wrap
);

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int COLX_W = $clog2(COLUMNS + TAB_CELLS);
	localparam int NSUB   = (COLUMNS - 1 + TAB_CELLS) / COLUMNS;
	localparam int LAST   = CELLS - COLUMNS;

	logic [CUR_W-1:0] cursor_q, cur_n;
	logic [COL_W-1:0] col_q, col_n, col_inc, col_tab;
	logic [AW-1:0]    base_q, base_next;
	logic [COL_W:0]   ci;
	logic [COLX_W-1:0] ct;
	logic [AW:0]      bsum;

	always_comb begin
		ci = {1'b0, col_q} + (COL_W+1)'(1);
		col_inc = (ci == (COL_W+1)'(COLUMNS)) ? '0 : ci[COL_W-1:0];
	end

	// column after a tab: NSUB conditional subtracts
	always_comb begin
		ct = COLX_W'(col_q) + COLX_W'(TAB_CELLS);
		for (int i = 0; i < NSUB; i++) begin
			if (ct >= COLX_W'(COLUMNS)) begin
				ct = ct - COLX_W'(COLUMNS);
			end
		end
		col_tab = ct[COL_W-1:0];
	end

	always_comb begin
		bsum = {1'b0, base_q} + (AW+1)'(COLUMNS);
		if (bsum >= (AW+1)'(CELLS)) begin
			bsum = bsum - (AW+1)'(CELLS);
		end
		base_next = bsum[AW-1:0];
	end

	always_comb begin
		cur_n = cursor_q;
		col_n = col_q;
		case (ctrl.op)
			tmcw_pkg::CUR_PRINT: begin
				cur_n = cursor_q + CUR_W'(1);
				col_n = col_inc;
			end
			tmcw_pkg::CUR_NL: begin
				cur_n = cursor_q + CUR_W'(COLUMNS) - CUR_W'(col_q);
				col_n = '0;
			end
			tmcw_pkg::CUR_CR: begin
				cur_n = cursor_q - CUR_W'(col_q);
				col_n = '0;
			end
			tmcw_pkg::CUR_TAB: begin
				cur_n = cursor_q + CUR_W'(TAB_CELLS);
				col_n = col_tab;
			end
			tmcw_pkg::CUR_VT: begin
				cur_n = cursor_q + CUR_W'(COLUMNS);
			end
			default: begin
			end
		endcase
	end

	assign wrap = (ctrl.op != tmcw_pkg::CUR_HOME) && (cur_n >= CUR_W'(CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
			base_q   <= '0;
		end else if (ctrl.go) begin
			if (ctrl.op == tmcw_pkg::CUR_HOME) begin
				cursor_q <= '0;
				col_q    <= '0;
				base_q   <= '0;
			end else if (wrap) begin
				// scroll: last row, same column, top row moves down one
				cursor_q <= CUR_W'(col_n) + CUR_W'(LAST);
				col_q    <= col_n;
				base_q   <= base_next;
			end else begin
				cursor_q <= cur_n;
				col_q    <= col_n;
			end
		end
	end

	assign cursor = cursor_q;
	assign base   = base_q;

endmodule

// ===== hdl/text_mode_console_writer.sv =====
// Top level: sequencer, address mapping, output register.
// Depends on tmcw_pkg, tmcw_screen_ram, tmcw_cursor.
//
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  in      | in_valid/in_ready, cmd, char_code, | in
//          | read_cell                          |
//  out     | out_valid/out_ready, cell_char,    | out
//          | cell_attr, cursor_pos              |
//  cfg     | cfg_wr_en, cfg_wr_data             | in
//
// Each word passes through accept, execute and result (a scroll or form feed
// puts a clear sweep before the result) on the one write and one read port of
// the screen store. Rows are kept as a ring: a scroll moves the top-row base
// and clears one row of COLUMNS cells. Form feed clears all ROWS*COLUMNS
// cells, one per cycle; the same sweep runs after reset, with in_ready low. A
// result not yet taken holds the next word in its result cycle.
module text_mode_console_writer #(
	parameter int COLUMNS   = tmcw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tmcw_pkg::DEF_ROWS,
	parameter int TAB_CELLS = tmcw_pkg::DEF_TAB_CELLS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] char_code,
	input  logic [10:0] read_cell,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr,
	output logic [10:0] cursor_pos,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int AW     = $clog2(CELLS);
	localparam int CUR_W  = $clog2(CELLS + COLUMNS + TAB_CELLS);
	localparam int LEFT_W = $clog2(CELLS + 1);
	localparam int OPOS_W = (CUR_W > tmcw_pkg::POS_W) ? CUR_W : tmcw_pkg::POS_W;
	localparam int CW     = tmcw_pkg::CELL_W;
	localparam int BW     = tmcw_pkg::CHAR_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_CLEAR = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic              init_q;
	logic [BW-1:0]     attr_q;
	logic              cmd_q;
	logic [BW-1:0]     ch_q;
	logic [10:0]       rcell_q;
	logic              rd_ok_q;
	logic [AW-1:0]     clr_addr_q;
	logic [LEFT_W-1:0] clr_left_q;
	logic              out_valid_q;
	logic [BW-1:0]     cell_char_q, cell_attr_q;
	logic [10:0]       cursor_pos_q;

	tmcw_pkg::cur_ctrl_t cur_ctrl;
	logic [2:0]        op;
	logic [CUR_W-1:0]  cursor;
	logic [AW-1:0]     base;
	logic              wrap;
	logic              rd_in_range;
	logic [31:0]       rcell_ext;
	logic [AW-1:0]     cur_lin;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [CW-1:0]     mem_wdata, mem_rdata;
	logic [OPOS_W-1:0] pos_ext;

	// logical cell to physical cell, rows rotated by the scroll base
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] lin, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, lin} + {1'b0, b};
		if (s >= (AW+1)'(CELLS)) begin
			s = s - (AW+1)'(CELLS);
		end
		return s[AW-1:0];
	endfunction

	always_comb begin
		op = tmcw_pkg::CUR_NONE;
		if (cmd_q == tmcw_pkg::CMD_PUT) begin
			unique case (ch_q)
				tmcw_pkg::BYTE_NUL: op = tmcw_pkg::CUR_NONE;
				tmcw_pkg::BYTE_FF:  op = tmcw_pkg::CUR_HOME;
				tmcw_pkg::BYTE_NL:  op = tmcw_pkg::CUR_NL;
				tmcw_pkg::BYTE_CR:  op = tmcw_pkg::CUR_CR;
				tmcw_pkg::BYTE_TAB: op = tmcw_pkg::CUR_TAB;
				tmcw_pkg::BYTE_VT:  op = tmcw_pkg::CUR_VT;
				default:            op = tmcw_pkg::CUR_PRINT;
			endcase
		end
		cur_ctrl.go = (state_q == ST_EXEC);
		cur_ctrl.op = op;
	end

	tmcw_cursor #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_CELLS(TAB_CELLS)
	) u_cursor (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (cur_ctrl),
		.cursor(cursor),
		.base  (base),
		.wrap  (wrap)
	);

	assign rcell_ext   = 32'(rcell_q);
	assign rd_in_range = rcell_ext < 32'(CELLS);
	assign cur_lin     = cursor[AW-1:0];

	// the cursor is always on screen between words
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = phys(rcell_ext[AW-1:0], base);
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_EXEC) begin
			mem_waddr = phys(cur_lin, base);
			mem_wdata = {attr_q, ch_q};
			mem_we    = (op == tmcw_pkg::CUR_PRINT);
			mem_re    = (cmd_q == tmcw_pkg::CMD_READ) && rd_in_range;
		end
	end

	tmcw_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW),
		.DW   (CW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tmcw_pkg::ATTR_RESET;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q   <= cmd;
			ch_q    <= char_code;
			rcell_q <= read_cell;
		end
		if (state_q == ST_EXEC) begin
			rd_ok_q <= (cmd_q == tmcw_pkg::CMD_READ) && rd_in_range;
		end
	end

	assign pos_ext = OPOS_W'(cursor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			init_q       <= 1'b1;
			clr_addr_q   <= '0;
			clr_left_q   <= LEFT_W'(CELLS);
			out_valid_q  <= 1'b0;
			cell_char_q  <= '0;
			cell_attr_q  <= '0;
			cursor_pos_q <= '0;
		end else begin
			// in the result cycle the register is reloaded below instead
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (op == tmcw_pkg::CUR_HOME) begin
						clr_addr_q <= '0;
						clr_left_q <= LEFT_W'(CELLS);
						state_q    <= ST_CLEAR;
					end else if (wrap) begin
						// old top row becomes the new bottom row
						clr_addr_q <= base;
						clr_left_q <= LEFT_W'(COLUMNS);
						state_q    <= ST_CLEAR;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					clr_left_q <= clr_left_q - LEFT_W'(1);
					if (clr_left_q == LEFT_W'(1)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						cell_char_q  <= rd_ok_q ? mem_rdata[BW-1:0] : '0;
						cell_attr_q  <= rd_ok_q ? mem_rdata[CW-1:BW] : '0;
						cursor_pos_q <= pos_ext[tmcw_pkg::POS_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;
	assign cursor_pos = cursor_pos_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EXEC)
		else $error("accepted word did not enter execute");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> clr_left_q != '0)
		else $error("clear sweep ran past its count");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_EXEC || state_q == ST_CLEAR))
		else $error("store written outside execute or clear");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cursor < CUR_W'(CELLS))
		else $error("cursor off screen between words");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(cursor_pos_q))
		else $error("pending result overwritten");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for text_mode_console_writer: a screen and cursor
// predictor, a word sender with bursts and gaps, and a receiver with stalls.
// Depends on tmcw_pkg and the RTL of text_mode_console_writer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS   = tmcw_pkg::DEF_COLUMNS;
	localparam int ROWS      = tmcw_pkg::DEF_ROWS;
	localparam int TAB_CELLS = tmcw_pkg::DEF_TAB_CELLS;
	localparam int CELLS     = COLUMNS * ROWS;
	localparam int LAST_ROW  = CELLS - COLUMNS;

	typedef struct packed {
		logic [tmcw_pkg::CHAR_W-1:0] ch;
		logic [tmcw_pkg::CHAR_W-1:0] attr;
		logic [tmcw_pkg::POS_W-1:0]  pos;
	} cell_result_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic              cmd         = tmcw_pkg::CMD_PUT;
	logic [7:0]        char_code   = '0;
	logic [10:0]       read_cell   = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [7:0]        cell_char;
	logic [7:0]        cell_attr;
	logic [10:0]       cursor_pos;
	logic              cfg_wr_en   = 1'b0;
	logic [7:0]        cfg_wr_data = '0;

	// predicted screen contents and cursor
	logic [tmcw_pkg::CELL_W-1:0] screen_model [CELLS];
	int unsigned       model_cursor = 0;
	logic [7:0]        model_attr   = tmcw_pkg::ATTR_RESET;
	cell_result_t      due_results [$];
	int                mismatch_count = 0;

	// receiver hold-off request, written by the test, counted by the receiver
	int                hold_len = 0;
	int                hold_seq = 0;
	int                hold_seen = 0;
	int                hold_left = 0;
	int                pat_age = 0;
	logic [15:0]       rx_pattern = '1;

	text_mode_console_writer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.char_code  (char_code),
		.read_cell  (read_cell),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr),
		.cursor_pos (cursor_pos),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	initial begin
		foreach (screen_model[i])
			screen_model[i] = '0;
	end

	task automatic console_apply(input logic c, input logic [7:0] ch, input logic [10:0] idx,
		output cell_result_t r);
		int unsigned col;
		int i;
		r = '0;
		if (c == tmcw_pkg::CMD_READ) begin
			if (idx < CELLS) begin
				r.ch   = screen_model[idx][7:0];
				r.attr = screen_model[idx][15:8];
			end
		end else if (ch != tmcw_pkg::BYTE_NUL) begin
			col = model_cursor % COLUMNS;
			if (ch == tmcw_pkg::BYTE_FF) begin
				foreach (screen_model[j])
					screen_model[j] = '0;
				model_cursor = 0;
			end else begin
				case (ch)
					tmcw_pkg::BYTE_NL:  model_cursor += COLUMNS - col;
					tmcw_pkg::BYTE_CR:  model_cursor -= col;
					tmcw_pkg::BYTE_TAB: model_cursor += TAB_CELLS;
					tmcw_pkg::BYTE_VT:  model_cursor += COLUMNS;
					default: begin
						if (model_cursor < CELLS)
							screen_model[model_cursor] = {model_attr, ch};
						model_cursor += 1;
					end
				endcase
				// past the end: scroll up one row, blank the bottom row
				if (model_cursor >= CELLS) begin
					for (i = 0; i < LAST_ROW; i++)
						screen_model[i] = screen_model[i + COLUMNS];
					for (i = LAST_ROW; i < CELLS; i++)
						screen_model[i] = '0;
					model_cursor = model_cursor % COLUMNS + LAST_ROW;
				end
			end
		end
		r.pos = tmcw_pkg::POS_W'(model_cursor);
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word: char %h attr %h cursor %0d",
					cell_char, cell_attr, cursor_pos));
			end else begin
				want = due_results.pop_front();
				if (cell_char !== want.ch || cell_attr !== want.attr
						|| cursor_pos !== want.pos)
					report_mismatch($sformatf(
						"wrong word: char %h/%h attr %h/%h cursor %0d/%0d (exp/got)",
						want.ch, cell_char, want.attr, cell_attr, want.pos, cursor_pos));
			end
		end
	end

	// receiver: rotating stall pattern, replaced now and then, plus hold-offs
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (pat_age == 0) begin
				pat_age = $urandom_range(32, 160);
				rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
			end
			pat_age--;
			out_ready <= rx_pattern[0];
			rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
		end
	end

	task automatic send_word(input logic c, input logic [7:0] ch, input logic [10:0] idx);
		cell_result_t r;
		in_valid  <= 1'b1;
		cmd       <= c;
		char_code <= ch;
		read_cell <= idx;
		do @(posedge clk); while (!in_ready);
		console_apply(c, ch, idx, r);
		due_results.push_back(r);
	endtask

	task automatic put_char(input logic [7:0] ch);
		send_word(tmcw_pkg::CMD_PUT, ch, 11'($urandom));
	endtask

	task automatic read_cell_at(input logic [10:0] idx);
		send_word(tmcw_pkg::CMD_READ, 8'($urandom), idx);
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic set_attribute(input logic [7:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_attr = v;
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return tmcw_pkg::BYTE_NUL;
		if (r < 5)
			return ($urandom_range(0, 3) == 0) ? tmcw_pkg::BYTE_FF : tmcw_pkg::BYTE_CR;
		if (r < 9)
			return tmcw_pkg::BYTE_NL;
		if (r < 12)
			return tmcw_pkg::BYTE_TAB;
		if (r < 14)
			return tmcw_pkg::BYTE_VT;
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic test_idle_reads;
		read_cell_at(11'd0);
		read_cell_at(11'(CELLS - 1));
		read_cell_at(11'(CELLS));
		read_cell_at(11'h7FF);
	endtask

	task automatic test_put_bytes;
		put_char(8'h41);
		put_char(8'hFF);
		put_char(8'h80);
		put_char(8'h01);
		put_char(8'd7);
		put_char(8'd8);
		put_char(tmcw_pkg::BYTE_NUL);
		send_word(tmcw_pkg::CMD_PUT, 8'h7E, 11'h7FF);
		send_word(tmcw_pkg::CMD_READ, 8'hFF, 11'd0);
		read_cell_at(11'd1);
		read_cell_at(11'd6);
		read_cell_at(11'd7);
		put_char(tmcw_pkg::BYTE_TAB);
		put_char(tmcw_pkg::BYTE_CR);
		put_char(tmcw_pkg::BYTE_NL);
		put_char(tmcw_pkg::BYTE_VT);
		put_char(8'h5A);
		read_cell_at(11'(2 * COLUMNS));
		put_char(tmcw_pkg::BYTE_FF);
		read_cell_at(11'd0);
	endtask

	task automatic test_attribute_extremes;
		set_attribute(8'h00);
		put_char(8'h5A);
		set_attribute(8'hFF);
		put_char(8'h7A);
		read_cell_at(11'd0);
		read_cell_at(11'd1);
	endtask

	task automatic test_scroll;
		int i;
		put_char(tmcw_pkg::BYTE_FF);
		for (i = 0; i < ROWS - 1; i++)
			put_char(tmcw_pkg::BYTE_VT);
		for (i = 0; i < COLUMNS / TAB_CELLS - 1; i++)
			put_char(tmcw_pkg::BYTE_TAB);
		for (i = 0; i < TAB_CELLS; i++)
			put_char(8'(8'h61 + i));
		for (i = LAST_ROW - TAB_CELLS; i < LAST_ROW; i++)
			read_cell_at(11'(i));
		read_cell_at(11'(CELLS - 1));
		for (i = 0; i < COLUMNS / TAB_CELLS - 1; i++)
			put_char(tmcw_pkg::BYTE_TAB);
		put_char(8'h65);
		put_char(8'h66);
		// tab overshooting the last cell keeps the overshoot column
		put_char(tmcw_pkg::BYTE_TAB);
		put_char(tmcw_pkg::BYTE_VT);
		put_char(tmcw_pkg::BYTE_NL);
		put_char(tmcw_pkg::BYTE_CR);
		for (i = LAST_ROW - 3 * COLUMNS - TAB_CELLS; i < LAST_ROW - 3 * COLUMNS; i++)
			read_cell_at(11'(i));
		read_cell_at(11'(LAST_ROW - 4));
		read_cell_at(11'(LAST_ROW - 2));
	endtask

	task automatic test_backpressure;
		int i;
		wait_drained();
		hold_len <= 400;
		hold_seq <= hold_seq + 1;
		for (i = 0; i < 48; i++)
			put_char(8'($urandom_range(32, 126)));
		for (i = 0; i < 8; i++)
			read_cell_at(11'($urandom_range(0, CELLS - 1)));
		wait_drained();
	endtask

	task automatic test_random_stream(input int words, input logic [7:0] attr);
		int done;
		int burst_left;
		int gap;
		logic [7:0] ch;
		set_attribute(attr);
		done = 0;
		burst_left = 0;
		while (done < words) begin
			if ($urandom_range(0, 99) < 22) begin
				if ($urandom_range(0, 7) == 0)
					read_cell_at(11'($urandom));
				else
					read_cell_at(11'($urandom_range(0, CELLS - 1)));
				done++;
			end else begin
				ch = pick_byte();
				put_char(ch);
				if (ch != tmcw_pkg::BYTE_NUL)
					done++;
			end
			if (burst_left != 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 31);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_reads();
		test_put_bytes();
		test_attribute_extremes();
		test_scroll();
		test_backpressure();
		test_random_stream(240, 8'($urandom));
		test_random_stream(160, 8'hFF);
		test_random_stream(160, 8'h00);
		test_random_stream(160, tmcw_pkg::ATTR_RESET);
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
